// ===== src/alu16_pkg.sv =====
// Package for the 16-opcode ALU: opcode encoding, flag bundle and I/O width.
package alu16_pkg;

    localparam int IO_BITS = 16;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_AND  = 4'd2,
        OP_OR   = 4'd3,
        OP_XOR  = 4'd4,
        OP_NAND = 4'd5,
        OP_NOR  = 4'd6,
        OP_NOTA = 4'd7,
        OP_PASSA = 4'd8,
        OP_PASSB = 4'd9,
        OP_SHL  = 4'd10,
        OP_SHR  = 4'd11,
        OP_ROL  = 4'd12,
        OP_ROR  = 4'd13,
        OP_CMP  = 4'd14,
        OP_SYS  = 4'd15
    } opcode_t;

    typedef struct packed {
        logic zero;
        logic carry;
        logic overflow;
    } flags_t;

endpackage

// ===== src/alu16_core.sv =====
// Combinational ALU datapath: adder, logic unit, one-bit shifter and flags.
module alu16_core #(
    parameter int WORD_BITS = 16
) (
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    input  alu16_pkg::opcode_t   op,
    output logic [WORD_BITS-1:0] res,
    output alu16_pkg::flags_t    flags
);
    import alu16_pkg::*;

    logic                 is_sub;
    logic [WORD_BITS-1:0] b_eff;
    logic [WORD_BITS:0]   sum_full;
    logic [WORD_BITS-1:0] sum;
    logic                 cout;
    logic                 c_msb;
    logic                 add_ovf;

    // subtract and compare share the adder: A + ~B + 1
    assign is_sub   = (op == OP_SUB) || (op == OP_CMP);
    assign b_eff    = is_sub ? ~b : b;
    assign sum_full = {1'b0, a} + {1'b0, b_eff} + {{WORD_BITS{1'b0}}, is_sub};
    assign sum      = sum_full[WORD_BITS-1:0];
    assign cout     = sum_full[WORD_BITS];
    assign c_msb    = a[WORD_BITS-1] ^ b_eff[WORD_BITS-1] ^ sum[WORD_BITS-1];
    assign add_ovf  = c_msb ^ cout;

    always_comb
    begin
        res            = '0;
        flags.carry    = 1'b0;
        flags.overflow = 1'b0;
        case (op)
            OP_ADD:
            begin
                res            = sum;
                flags.carry    = cout;
                flags.overflow = add_ovf;
            end
            OP_SUB:
            begin
                res            = sum;
                flags.carry    = ~cout;
                flags.overflow = add_ovf;
            end
            OP_AND:   res = a & b;
            OP_OR:    res = a | b;
            OP_XOR:   res = a ^ b;
            OP_NAND:  res = ~(a & b);
            OP_NOR:   res = ~(a | b);
            OP_NOTA:  res = ~a;
            OP_PASSA: res = a;
            OP_PASSB: res = b;
            OP_SHL:
            begin
                res         = {a[WORD_BITS-2:0], 1'b0};
                flags.carry = a[WORD_BITS-1];
            end
            OP_SHR:
            begin
                res         = {1'b0, a[WORD_BITS-1:1]};
                flags.carry = a[0];
            end
            OP_ROL:
            begin
                res         = {a[WORD_BITS-2:0], a[WORD_BITS-1]};
                flags.carry = a[WORD_BITS-1];
            end
            OP_ROR:
            begin
                res         = {a[0], a[WORD_BITS-1:1]};
                flags.carry = a[0];
            end
            OP_CMP:
            begin
                res            = '0;
                flags.carry    = ~cout;
                flags.overflow = add_ovf;
            end
            default:
            begin
                res = '0;
            end
        endcase
        // compare takes its zero flag from the difference
        flags.zero = (op == OP_CMP) ? (sum == '0) : (res == '0);
    end

endmodule

// ===== src/alu_16_op_with_flags.sv =====
// Top level: two-stage registered ALU with valid/ready request channels.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------------
//   in      | input     | in_valid / in_ready   | operand_a, operand_b, operation
//   out     | output    | out_valid / out_ready | result_word, zero_flag, carry_flag,
//           |           |                       | overflow_flag
//
// One request per cycle sustained while out_ready stays high; a request passes the input
// register, then the result register, and out_valid rises once the result register loads.
// Reset clears both stage valid bits; payload registers are not reset.
// A stalled out stage holds its result; the input stage keeps accepting until both
// stages are full and out_ready is low, then in_ready drops.
module alu_16_op_with_flags #(
    parameter int WORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [alu16_pkg::IO_BITS-1:0] operand_a,
    input  logic [alu16_pkg::IO_BITS-1:0] operand_b,
    input  logic [3:0]                   operation,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [alu16_pkg::IO_BITS-1:0] result_word,
    output logic                         zero_flag,
    output logic                         carry_flag,
    output logic                         overflow_flag
);
    import alu16_pkg::*;

    localparam int EXT_BITS = (WORD_BITS > IO_BITS) ? WORD_BITS : IO_BITS;

    logic [EXT_BITS-1:0]  a_ext;
    logic [EXT_BITS-1:0]  b_ext;
    logic [EXT_BITS-1:0]  res_ext;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [WORD_BITS-1:0] s1_a_reg;
    logic [WORD_BITS-1:0] s1_b_reg;
    opcode_t              s1_op_reg;
    logic                 s1_adv;

    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    logic [WORD_BITS-1:0] s2_res_reg;
    flags_t               s2_flags_reg;

    logic [WORD_BITS-1:0] alu_res;
    flags_t               core_flags;

    assign a_ext = EXT_BITS'(operand_a);
    assign b_ext = EXT_BITS'(operand_b);

    assign s1_adv        = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready      = !s1_valid_reg || s1_adv;
    assign s1_valid_next = (in_valid && in_ready) || (s1_valid_reg && !s1_adv);
    assign s2_valid_next = s1_adv || (s2_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_a_reg  <= a_ext[WORD_BITS-1:0];
            s1_b_reg  <= b_ext[WORD_BITS-1:0];
            s1_op_reg <= opcode_t'(operation);
        end
        if (s1_adv)
        begin
            s2_res_reg   <= alu_res;
            s2_flags_reg <= core_flags;
        end
    end

    alu16_core #(
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .a     (s1_a_reg),
        .b     (s1_b_reg),
        .op    (s1_op_reg),
        .res   (alu_res),
        .flags (core_flags)
    );

    assign res_ext       = EXT_BITS'(s2_res_reg);
    assign result_word   = res_ext[IO_BITS-1:0];
    assign zero_flag     = s2_flags_reg.zero;
    assign carry_flag    = s2_flags_reg.carry;
    assign overflow_flag = s2_flags_reg.overflow;
    assign out_valid     = s2_valid_reg;

`ifndef SYNTHESIS
    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> s2_valid_reg)
        else $error("advanced request did not reach the result stage");

    a_empty_out_ready_in: assert property (@(posedge clk) disable iff (!rst_n)
        !s2_valid_reg |-> in_ready)
        else $error("input stalled while result stage empty");

    a_stalled_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_op_reg)))
        else $error("stalled input stage lost its request");
`endif

endmodule

// ===== tb/alu_flag_checker.sv =====
// Checker for the ALU: watches both channels, predicts each result and compares it.
module alu_flag_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [alu16_pkg::IO_BITS-1:0] operand_a,
    input  logic [alu16_pkg::IO_BITS-1:0] operand_b,
    input  logic [3:0]                    operation,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [alu16_pkg::IO_BITS-1:0] result_word,
    input  logic                          zero_flag,
    input  logic                          carry_flag,
    input  logic                          overflow_flag,
    output int                            mismatches,
    output int                            outstanding
);
    import alu16_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [IO_BITS-1:0] word;
        logic               zero;
        logic               carry;
        logic               overflow;
    } alu_outcome_t;

    alu_outcome_t awaited[$];
    int           fail_count = 0;
    int           backlog = 0;

    assign mismatches  = fail_count;
    assign outstanding = backlog;

    function automatic alu_outcome_t alu_outcome(logic [IO_BITS-1:0] a, logic [IO_BITS-1:0] b,
                                                 opcode_t op);
        alu_outcome_t       o;
        logic [IO_BITS:0]   sum;
        logic [IO_BITS-1:0] addend;
        logic [IO_BITS-1:0] carries;
        o.word     = '0;
        o.carry    = 1'b0;
        o.overflow = 1'b0;
        sum        = '0;
        case (op)
            OP_ADD, OP_SUB, OP_CMP:
            begin
                // sub and cmp: a + ~b + 1, carry reported as borrow
                addend     = (op == OP_ADD) ? b : ~b;
                sum        = {1'b0, a} + {1'b0, addend} + {{IO_BITS{1'b0}}, op != OP_ADD};
                carries    = a ^ addend ^ sum[IO_BITS-1:0];
                o.carry    = (op == OP_ADD) ? sum[IO_BITS] : ~sum[IO_BITS];
                o.overflow = carries[IO_BITS-1] ^ sum[IO_BITS];
                o.word     = (op == OP_CMP) ? '0 : sum[IO_BITS-1:0];
            end
            OP_AND:   o.word = a & b;
            OP_OR:    o.word = a | b;
            OP_XOR:   o.word = a ^ b;
            OP_NAND:  o.word = ~(a & b);
            OP_NOR:   o.word = ~(a | b);
            OP_NOTA:  o.word = ~a;
            OP_PASSA: o.word = a;
            OP_PASSB: o.word = b;
            OP_SHL:
            begin
                o.word  = {a[IO_BITS-2:0], 1'b0};
                o.carry = a[IO_BITS-1];
            end
            OP_SHR:
            begin
                o.word  = {1'b0, a[IO_BITS-1:1]};
                o.carry = a[0];
            end
            OP_ROL:
            begin
                o.word  = {a[IO_BITS-2:0], a[IO_BITS-1]};
                o.carry = a[IO_BITS-1];
            end
            OP_ROR:
            begin
                o.word  = {a[0], a[IO_BITS-1:1]};
                o.carry = a[0];
            end
            default:  o.word = '0;
        endcase
        o.zero = (op == OP_CMP) ? (sum[IO_BITS-1:0] == '0) : (o.word == '0);
        return o;
    endfunction

    always @(posedge clk)
    begin : watch
        alu_outcome_t due;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                awaited.push_back(alu_outcome(operand_a, operand_b, opcode_t'(operation)));
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                begin
                    $error("result with no request outstanding: result_word=%h", result_word);
                    fail_count++;
                end
                else
                begin
                    due = awaited.pop_front();
                    if (result_word !== due.word)
                    begin
                        $error("result_word: expected %h, got %h", due.word, result_word);
                        fail_count++;
                    end
                    if (zero_flag !== due.zero)
                    begin
                        $error("zero_flag: expected %b, got %b", due.zero, zero_flag);
                        fail_count++;
                    end
                    if (carry_flag !== due.carry)
                    begin
                        $error("carry_flag: expected %b, got %b", due.carry, carry_flag);
                        fail_count++;
                    end
                    if (overflow_flag !== due.overflow)
                    begin
                        $error("overflow_flag: expected %b, got %b", due.overflow, overflow_flag);
                        fail_count++;
                    end
                end
            end
            backlog = awaited.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the ALU: clock, reset, request stimulus, result back-pressure, verdict.
module tb;
    import alu16_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [IO_BITS-1:0] operand_a = '0;
    logic [IO_BITS-1:0] operand_b = '0;
    logic [3:0]         operation = OP_ADD;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [IO_BITS-1:0] result_word;
    logic               zero_flag;
    logic               carry_flag;
    logic               overflow_flag;
    logic               calm = 1'b0;
    int                 mismatches;
    int                 outstanding;
    int                 idle_cycles = 0;

    alu_16_op_with_flags #(.WORD_BITS(16)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .operation     (operation),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_word   (result_word),
        .zero_flag     (zero_flag),
        .carry_flag    (carry_flag),
        .overflow_flag (overflow_flag)
    );

    alu_flag_checker i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .operation     (operation),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_word   (result_word),
        .zero_flag     (zero_flag),
        .carry_flag    (carry_flag),
        .overflow_flag (overflow_flag),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue(logic [IO_BITS-1:0] a, logic [IO_BITS-1:0] b, opcode_t op);
        while (!calm && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        operation <= op;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    function automatic logic [IO_BITS-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            4:       return 16'h0001;
            default: return IO_BITS'($urandom);
        endcase
    endfunction

    initial
    begin
        forever
        begin
            @(negedge clk);
            out_ready <= calm || ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int n;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        issue(16'hFFFF, 16'h0001, OP_ADD);
        issue(16'h7FFF, 16'h0001, OP_ADD);
        issue(16'h8000, 16'h8000, OP_ADD);
        issue(16'h0000, 16'h0001, OP_SUB);
        issue(16'h8000, 16'h0001, OP_SUB);
        issue(16'h1234, 16'h1234, OP_SUB);
        issue(16'hFFFF, 16'hFFFF, OP_AND);
        issue(16'h0000, 16'h0000, OP_OR);
        issue(16'hFFFF, 16'hFFFF, OP_XOR);
        issue(16'hFFFF, 16'hFFFF, OP_NAND);
        issue(16'h0000, 16'h0000, OP_NOR);
        issue(16'hFFFF, 16'h0000, OP_NOTA);
        issue(16'h0000, 16'hFFFF, OP_PASSA);
        issue(16'h0000, 16'hFFFF, OP_PASSB);
        issue(16'h8000, 16'h0000, OP_SHL);
        issue(16'h0001, 16'h0000, OP_SHR);
        issue(16'h8001, 16'h0000, OP_ROL);
        issue(16'h8001, 16'h0000, OP_ROR);
        issue(16'hABCD, 16'hABCD, OP_CMP);
        issue(16'h8000, 16'h0001, OP_CMP);
        issue(16'h0000, 16'hFFFF, OP_CMP);
        issue(16'hFFFF, 16'hFFFF, OP_SYS);

        for (n = 0; n < 1950; n++)
        begin
            if (n == 400 || n == 1400)
            begin
                // drain the pipe before sending more
                in_valid <= 1'b0;
                do @(negedge clk); while (outstanding != 0);
            end
            calm = (n >= 700 && n < 1000);
            issue(pick_operand(), pick_operand(), opcode_t'($urandom_range(0, 15)));
        end
        calm = 1'b0;
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (6) @(negedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
